// ===== rtl/ordered_array_list_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ordered array list engine
// Shared property forms used by the RTL files that carry assertions.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_LIST_ENGINE_ASSERT_SVH
`define ORDERED_ARRAY_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define OALE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define OALE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/oale_pkg.sv =====
// ----------------------------------------------------------------------------
// oale_pkg
// Types, field layouts and request codes of the ordered array list engine.
// ----------------------------------------------------------------------------
package oale_pkg;

  // List capacity and the widths that follow from it.
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Item field widths.
  localparam int TYPE_W  = 3;
  localparam int POS_W   = 7;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 2;
  localparam int FPOS_W  = 6;
  localparam int COUNT_W = 7;

  // Input tdata layout, lowest bit first.
  localparam int IN_TYPE_LSB = 0;
  localparam int IN_POS_LSB  = IN_TYPE_LSB + TYPE_W;
  localparam int IN_VAL_LSB  = IN_POS_LSB + POS_W;
  localparam int IN_BITS     = IN_VAL_LSB + WORD_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;

  // Output tdata layout, lowest bit first.
  localparam int OUT_STAT_LSB  = 0;
  localparam int OUT_RDATA_LSB = OUT_STAT_LSB + STAT_W;
  localparam int OUT_FPOS_LSB  = OUT_RDATA_LSB + WORD_W;
  localparam int OUT_CNT_LSB   = OUT_FPOS_LSB + FPOS_W;
  localparam int OUT_BITS      = OUT_CNT_LSB + COUNT_W;
  localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

  // Count value of a full list.
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // Request codes.
  localparam logic [TYPE_W-1:0] REQ_APPEND  = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_INSERT  = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_GET     = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_REPLACE = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_REMOVE  = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_FIND    = 3'd5;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_RANGE    = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

endpackage

// ===== rtl/oale_ram.sv =====
// ----------------------------------------------------------------------------
// oale_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module oale_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/ordered_array_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// Ordered list of signed 32-bit words with append, insert, get, replace,
// remove and find requests, one result item per request item.
// ----------------------------------------------------------------------------
// The list lives in a 64-entry RAM with one write and one registered read
// port; a small sequencer walks it one entry per cycle. The block takes one
// request item at a time and drops in_tready while it works. Append, replace,
// failed range or full checks, find on an empty list, insert at the end,
// removal of the last entry and unused codes need no walk; get reads a single
// entry. Insert at an index p below the count n and remove at an index p
// below n - 1 walk the entries that move, since every moved entry costs one
// RAM read and one write. Find compares one entry per cycle and stops at the
// first match. The slowest item is a failed find on a full list, set by the
// single RAM read port. The result register lets the next item be accepted
// while a result still waits to be taken.
// ----------------------------------------------------------------------------
`include "ordered_array_list_engine_assert.svh"

module ordered_array_list_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: req_type[2:0], position[9:3], item_value[41:10], zero fill
  input  logic [oale_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_tdata: status[1:0], read_data[33:2], found_position[39:34],
  // entry_count[46:40], zero fill
  output logic [oale_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready
);

  import oale_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // Sequencer and list state.
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [TYPE_W-1:0]   kind_r, kind_nxt;
  logic [ADDR_W-1:0]   pos_r, pos_nxt;
  logic [WORD_W-1:0]   val_r, val_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [ADDR_W-1:0]   stop_r, stop_nxt;
  logic [ADDR_W-1:0]   paddr_r, paddr_nxt;
  logic                issue_r, issue_nxt;
  logic                pend_r, pend_nxt;

  // Result of the current request.
  status_t             res_status_r, res_status_nxt;
  logic [WORD_W-1:0]   res_rdata_r, res_rdata_nxt;
  logic [ADDR_W-1:0]   res_fpos_r, res_fpos_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [WORD_W-1:0]   out_rdata_r, out_rdata_nxt;
  logic [FPOS_W-1:0]   out_fpos_r, out_fpos_nxt;
  logic [COUNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  // RAM ports.
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [WORD_W-1:0]   ram_rdata;

  // Input fields and helpers.
  logic [TYPE_W-1:0]   in_type;
  logic [POS_W-1:0]    in_pos;
  logic [WORD_W-1:0]   in_val;
  logic                accept;
  logic                full;
  logic [CNT_W-1:0]    cnt_m1;
  logic [POS_W-1:0]    pos_p1;
  logic                walk_down;

  assign in_type = in_tdata[IN_TYPE_LSB +: TYPE_W];
  assign in_pos  = in_tdata[IN_POS_LSB +: POS_W];
  assign in_val  = in_tdata[IN_VAL_LSB +: WORD_W];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign full      = (cnt_r == CNT_FULL);
  assign cnt_m1    = cnt_r - CNT_W'(1);
  assign pos_p1    = in_pos + POS_W'(1);
  assign walk_down = (kind_r == REQ_INSERT);

  // Element store.
  oale_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (addr_r),
    .rd_data (ram_rdata)
  );

  // Request decode, walk sequencer and result hand-off.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    kind_nxt       = kind_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    addr_nxt       = addr_r;
    stop_nxt       = stop_r;
    paddr_nxt      = paddr_r;
    issue_nxt      = issue_r;
    pend_nxt       = pend_r;
    res_status_nxt = res_status_r;
    res_rdata_nxt  = res_rdata_r;
    res_fpos_nxt   = res_fpos_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_rdata_nxt  = out_rdata_r;
    out_fpos_nxt   = out_fpos_r;
    out_cnt_nxt    = out_cnt_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;

    // The downstream side takes the waiting result.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt       = in_type;
          pos_nxt        = in_pos[ADDR_W-1:0];
          val_nxt        = in_val;
          res_status_nxt = STAT_OK;
          res_rdata_nxt  = '0;
          res_fpos_nxt   = '0;
          issue_nxt      = 1'b1;
          pend_nxt       = 1'b0;
          state_nxt      = ST_DONE;
          unique case (in_type)
            REQ_APPEND: begin
              if (full) begin
                res_status_nxt = STAT_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_r[ADDR_W-1:0];
                ram_wdata = in_val;
                cnt_nxt   = cnt_r + CNT_W'(1);
              end
            end
            REQ_INSERT: begin
              if (in_pos > cnt_r) begin
                res_status_nxt = STAT_RANGE;
              end else if (full) begin
                res_status_nxt = STAT_FULL;
              end else if (in_pos == cnt_r) begin
                ram_we    = 1'b1;
                ram_waddr = in_pos[ADDR_W-1:0];
                ram_wdata = in_val;
                cnt_nxt   = cnt_r + CNT_W'(1);
              end else begin
                addr_nxt  = cnt_m1[ADDR_W-1:0];
                stop_nxt  = in_pos[ADDR_W-1:0];
                state_nxt = ST_WALK;
              end
            end
            REQ_GET: begin
              if (in_pos >= cnt_r) begin
                res_status_nxt = STAT_RANGE;
              end else begin
                addr_nxt  = in_pos[ADDR_W-1:0];
                stop_nxt  = in_pos[ADDR_W-1:0];
                state_nxt = ST_WALK;
              end
            end
            REQ_REPLACE: begin
              if (in_pos >= cnt_r) begin
                res_status_nxt = STAT_RANGE;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = in_pos[ADDR_W-1:0];
                ram_wdata = in_val;
              end
            end
            REQ_REMOVE: begin
              if (in_pos >= cnt_r) begin
                res_status_nxt = STAT_RANGE;
              end else if (pos_p1 == cnt_r) begin
                cnt_nxt = cnt_m1;
              end else begin
                addr_nxt  = pos_p1[ADDR_W-1:0];
                stop_nxt  = cnt_m1[ADDR_W-1:0];
                state_nxt = ST_WALK;
              end
            end
            REQ_FIND: begin
              if (cnt_r == '0) begin
                res_status_nxt = STAT_NOTFOUND;
              end else begin
                addr_nxt  = '0;
                stop_nxt  = cnt_m1[ADDR_W-1:0];
                state_nxt = ST_WALK;
              end
            end
            default: begin
              // Unused codes change nothing and report ok.
            end
          endcase
        end
      end

      ST_WALK: begin
        // Issue the next RAM read of the walk.
        if (issue_r) begin
          pend_nxt  = 1'b1;
          paddr_nxt = addr_r;
          if (addr_r == stop_r) begin
            issue_nxt = 1'b0;
          end else if (walk_down) begin
            addr_nxt = addr_r - ADDR_W'(1);
          end else begin
            addr_nxt = addr_r + ADDR_W'(1);
          end
        end else begin
          pend_nxt = 1'b0;
        end

        // Use the word read in the previous cycle.
        if (pend_r) begin
          unique case (kind_r)
            REQ_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = paddr_r + ADDR_W'(1);
              ram_wdata = ram_rdata;
            end
            REQ_REMOVE: begin
              ram_we    = 1'b1;
              ram_waddr = paddr_r - ADDR_W'(1);
              ram_wdata = ram_rdata;
            end
            REQ_GET: begin
              res_rdata_nxt = ram_rdata;
            end
            REQ_FIND: begin
              if (ram_rdata == val_r) begin
                res_fpos_nxt = paddr_r;
                issue_nxt    = 1'b0;
                pend_nxt     = 1'b0;
                state_nxt    = ST_DONE;
              end
            end
            default: begin
            end
          endcase
        end

        // Walk finished: close out the request.
        if (!issue_r && !pend_r) begin
          state_nxt = ST_DONE;
          unique case (kind_r)
            REQ_INSERT: begin
              ram_we    = 1'b1;
              ram_waddr = pos_r;
              ram_wdata = val_r;
              cnt_nxt   = cnt_r + CNT_W'(1);
            end
            REQ_REMOVE: begin
              cnt_nxt = cnt_m1;
            end
            REQ_FIND: begin
              res_status_nxt = STAT_NOTFOUND;
            end
            default: begin
            end
          endcase
        end
      end

      ST_DONE: begin
        // Move the result into the output register once it is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_rdata_nxt  = res_rdata_r;
          out_fpos_nxt   = FPOS_W'(res_fpos_r);
          out_cnt_nxt    = COUNT_W'(cnt_r);
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    addr_r       <= addr_nxt;
    stop_r       <= stop_nxt;
    paddr_r      <= paddr_nxt;
    res_status_r <= res_status_nxt;
    res_rdata_r  <= res_rdata_nxt;
    res_fpos_r   <= res_fpos_nxt;
    out_status_r <= out_status_nxt;
    out_rdata_r  <= out_rdata_nxt;
    out_fpos_r   <= out_fpos_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  // Output packing.
  always_comb begin
    out_tdata = '0;
    out_tdata[OUT_STAT_LSB +: STAT_W]   = out_status_r;
    out_tdata[OUT_RDATA_LSB +: WORD_W]  = out_rdata_r;
    out_tdata[OUT_FPOS_LSB +: FPOS_W]   = out_fpos_r;
    out_tdata[OUT_CNT_LSB +: COUNT_W]   = out_cnt_r;
  end
  assign out_tvalid = out_valid_r;

  // The count never passes the capacity.
  `OALE_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_FULL, "entry count above capacity")
  // An append to a list with room grows it by one in the next cycle.
  `OALE_ASSERT_NXT(a_append_grows, accept && (in_type == REQ_APPEND) && !full,
                   cnt_r == $past(cnt_r) + CNT_W'(1), "append did not grow the list")
  // Every RAM write stays at or below the current count.
  `OALE_ASSERT_IMP(a_write_bound, ram_we, CNT_W'(ram_waddr) <= cnt_r,
                   "element write beyond the end of the list")
  // A failed find reports index zero.
  `OALE_ASSERT_IMP(a_notfound_pos, out_valid_r && (out_status_r == STAT_NOTFOUND),
                   out_fpos_r == '0, "failed find with nonzero index")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list engine testbench
// Sends list requests over the input stream and checks each result item
// against a mirror of the list kept in the testbench. A short directed run
// covers empty-list errors, edge positions, extreme words and unused codes.
// Random phases then grow the list until it is full, shrink it to empty and
// mix all requests. Random stalls are applied on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
  import oale_pkg::*;

  // Unused request codes; the block answers them without changing the list.
  localparam logic [TYPE_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [TYPE_W-1:0] REQ_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 1550;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_PRINTED  = 200;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIX} phase_mode_t;

  // One expected result item.
  typedef struct {
    status_t             status;
    logic [WORD_W-1:0]   read_data;
    logic [FPOS_W-1:0]   found_pos;
    logic [COUNT_W-1:0]  count;
  } list_reply_t;

  // Mirror of the list plus the queue of result items still owed.
  class list_checker;
    logic [WORD_W-1:0] mirror_words [DEPTH];
    int                mirror_len;
    list_reply_t       pending_replies [$];
    int                errors;
    int                reply_index;

    function new();
      mirror_len  = 0;
      errors      = 0;
      reply_index = 0;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) begin
        $display("%0t mismatch: %s", $time, msg);
      end
    endtask

    // Apply one accepted request to the mirror and queue its result.
    function void note_request(logic [TYPE_W-1:0] kind, logic [POS_W-1:0] pos,
                               logic [WORD_W-1:0] word);
      list_reply_t r;
      int          n;
      int          p;
      n           = mirror_len;
      p           = int'(pos);
      r.status    = STAT_OK;
      r.read_data = '0;
      r.found_pos = '0;
      case (kind)
        REQ_APPEND: begin
          if (n >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            mirror_words[n] = word;
            mirror_len      = n + 1;
          end
        end
        REQ_INSERT: begin
          // The range check wins over the full check.
          if (p > n) begin
            r.status = STAT_RANGE;
          end else if (n >= DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            for (int i = n; i > p; i--) mirror_words[i] = mirror_words[i-1];
            mirror_words[p] = word;
            mirror_len      = n + 1;
          end
        end
        REQ_GET: begin
          if (p >= n) r.status = STAT_RANGE;
          else r.read_data = mirror_words[p];
        end
        REQ_REPLACE: begin
          if (p >= n) r.status = STAT_RANGE;
          else mirror_words[p] = word;
        end
        REQ_REMOVE: begin
          if (p >= n) begin
            r.status = STAT_RANGE;
          end else begin
            for (int i = p; i + 1 < n; i++) mirror_words[i] = mirror_words[i+1];
            mirror_len = n - 1;
          end
        end
        REQ_FIND: begin
          // First match wins.
          r.status = STAT_NOTFOUND;
          for (int i = 0; i < n; i++) begin
            if (mirror_words[i] == word) begin
              r.status    = STAT_OK;
              r.found_pos = FPOS_W'(i);
              break;
            end
          end
        end
        default: begin
        end
      endcase
      r.count = COUNT_W'(mirror_len);
      pending_replies.push_back(r);
    endfunction

    // Compare one accepted result item with the oldest expectation.
    task check_reply(logic [OUT_TDATA_W-1:0] d);
      list_reply_t exp;
      logic [STAT_W-1:0]  got_status;
      logic [WORD_W-1:0]  got_data;
      logic [FPOS_W-1:0]  got_fpos;
      logic [COUNT_W-1:0] got_count;
      got_status = d[OUT_STAT_LSB +: STAT_W];
      got_data   = d[OUT_RDATA_LSB +: WORD_W];
      got_fpos   = d[OUT_FPOS_LSB +: FPOS_W];
      got_count  = d[OUT_CNT_LSB +: COUNT_W];
      if (pending_replies.size() == 0) begin
        report("result item with no request outstanding");
        return;
      end
      exp = pending_replies.pop_front();
      if (got_status !== exp.status)
        report($sformatf("item %0d status %0d, want %0d", reply_index, got_status,
                         exp.status));
      if (got_data !== exp.read_data)
        report($sformatf("item %0d read_data %h, want %h", reply_index, got_data,
                         exp.read_data));
      if (got_fpos !== exp.found_pos)
        report($sformatf("item %0d found_position %0d, want %0d", reply_index,
                         got_fpos, exp.found_pos));
      if (got_count !== exp.count)
        report($sformatf("item %0d entry_count %0d, want %0d", reply_index,
                         got_count, exp.count));
      reply_index++;
    endtask
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;

  list_checker sb = new();
  bit          idle_on = 1'b1;

  ordered_array_list_engine u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always #6 clk = ~clk;

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Request mix per phase, as cumulative percentages of the six codes.
  function automatic logic [TYPE_W-1:0] pick_kind(phase_mode_t mode);
    logic [TYPE_W-1:0] codes [6];
    int cut [3][6];
    int r;
    codes = '{REQ_APPEND, REQ_INSERT, REQ_GET, REQ_REPLACE, REQ_REMOVE, REQ_FIND};
    cut   = '{'{35, 65, 75, 83, 88, 98},
              '{5, 10, 22, 32, 84, 98},
              '{15, 30, 50, 62, 90, 98}};
    r = $urandom_range(0, 99);
    for (int k = 0; k < 6; k++) begin
      if (r < cut[int'(mode)][k]) return codes[k];
    end
    return ($urandom_range(0, 1) != 0) ? REQ_SPARE_HI : REQ_SPARE_LO;
  endfunction

  // Mostly legal positions, some at the end of the list, some anywhere.
  function automatic logic [POS_W-1:0] pick_position(logic [TYPE_W-1:0] kind);
    int n;
    int r;
    n = sb.mirror_len;
    r = $urandom_range(0, 99);
    if (r < 8) return POS_W'($urandom_range(0, 127));
    if (r < 18) return POS_W'(n);
    if (kind == REQ_INSERT) return POS_W'($urandom_range(0, n));
    if (n == 0) return '0;
    return POS_W'($urandom_range(0, n - 1));
  endfunction

  // Words are random, extreme, or copies of stored ones so that finds hit
  // and duplicates exist.
  function automatic logic [WORD_W-1:0] pick_word(logic [TYPE_W-1:0] kind);
    int n;
    int r;
    n = sb.mirror_len;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (n > 0 && (r < 20 || (kind == REQ_FIND && r < 70)))
      return sb.mirror_words[$urandom_range(0, n - 1)];
    return $urandom;
  endfunction

  // Present one request item, wait for it to be taken, then maybe idle.
  task automatic send_request(logic [TYPE_W-1:0] kind, logic [POS_W-1:0] pos,
                              logic [WORD_W-1:0] word);
    logic [IN_TDATA_W-1:0] packed_item;
    int gap;
    packed_item = '0;
    packed_item[IN_TYPE_LSB +: TYPE_W] = kind;
    packed_item[IN_POS_LSB +: POS_W]   = pos;
    packed_item[IN_VAL_LSB +: WORD_W]  = word;
    in_tdata  <= packed_item;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_request(kind, pos, word);
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: stretches of ready with random stalls, sometimes none.
  initial begin : result_sink
    int run_len;
    int gap;
    forever begin
      if ($urandom_range(0, 4) == 0) begin
        run_len = $urandom_range(50, 300);
        gap     = 0;
      end else begin
        run_len = $urandom_range(1, 8);
        gap     = pick_gap();
      end
      out_tready <= 1'b1;
      repeat (run_len) @(posedge clk);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Check every result item taken.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_reply(out_tdata);
    end
  end

  // Stimulus.
  initial begin : stimulus
    phase_mode_t       mode;
    int                phase_len;
    int                sent;
    bit                first;
    logic [TYPE_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Errors on an empty list.
    send_request(REQ_GET, 7'd0, 32'h0);
    send_request(REQ_REMOVE, 7'd0, 32'h0);
    send_request(REQ_REPLACE, 7'd0, 32'h1);
    send_request(REQ_FIND, 7'd0, 32'h0);
    send_request(REQ_INSERT, 7'd1, 32'h2);
    // Build a short list with extreme words, inserting at front and end.
    send_request(REQ_INSERT, 7'd0, 32'h7FFF_FFFF);
    send_request(REQ_APPEND, 7'd0, 32'h8000_0000);
    send_request(REQ_APPEND, 7'd127, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 7'd3, 32'h0000_0000);
    send_request(REQ_INSERT, 7'd1, 32'h5555_5555);
    send_request(REQ_REPLACE, 7'd4, 32'hAAAA_AAAA);
    // Reads, searches and out-of-range positions.
    send_request(REQ_FIND, 7'd127, 32'hFFFF_FFFF);
    send_request(REQ_FIND, 7'd0, 32'h1234_5678);
    send_request(REQ_GET, 7'd0, 32'h0);
    send_request(REQ_GET, 7'd4, 32'h0);
    send_request(REQ_GET, 7'd5, 32'h0);
    send_request(REQ_GET, 7'd127, 32'h0);
    send_request(REQ_INSERT, 7'd64, 32'h3);
    // A duplicate word: the search reports the first copy.
    send_request(REQ_REPLACE, 7'd2, 32'h7FFF_FFFF);
    send_request(REQ_FIND, 7'd0, 32'h7FFF_FFFF);
    // Removal at the front, at the end and past the end.
    send_request(REQ_REMOVE, 7'd0, 32'h0);
    send_request(REQ_REMOVE, 7'd3, 32'h0);
    send_request(REQ_REMOVE, 7'd64, 32'h0);
    // Unused codes.
    send_request(REQ_SPARE_LO, 7'd0, 32'hFFFF_FFFF);
    send_request(REQ_SPARE_HI, 7'd127, 32'h0);

    // Random phases; the first one grows the list until it is full.
    sent  = 0;
    first = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      mode      = first ? MODE_GROW : phase_mode_t'($urandom_range(0, 2));
      phase_len = first ? 200 : $urandom_range(40, 200);
      idle_on   = ($urandom_range(0, 3) != 0);
      first     = 1'b0;
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        kind = pick_kind(mode);
        pos  = pick_position(kind);
        word = pick_word(kind);
        send_request(kind, pos, word);
        sent++;
      end
    end

    // Drain the outstanding results, then watch for strays.
    in_tvalid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #15_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
